### rtl/mhws_pkg.sv
package mhws_pkg;

   localparam int SPEED_BITS = 8;
   localparam int SPIN_BITS  = 9;
   localparam int GAIN_BITS  = 16;
   localparam int WHEEL_BITS = 10;

   localparam int WHEEL_LIMIT = 511;
   localparam int Y_AS_ZERO   = 60;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd11796;

endpackage

### rtl/mhws_sqrt.sv
// pipelined integer square root, one result bit per stage
module mhws_sqrt #(
   parameter int RB = 26,
   parameter int SW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [2*RB-1:0] radicand,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [RB-1:0]   root,
   output logic [SW-1:0]   out_side
);

   localparam int RW = RB + 3;

   logic [RW-1:0]   rem_ff  [RB];
   logic [RB-1:0]   root_ff [RB];
   logic [2*RB-1:0] rad_ff  [RB];
   logic [SW-1:0]   side_ff [RB];
   logic [RB-1:0]   valid_ff;

   genvar k;
   generate
      for (k = 0; k < RB; k++) begin : g_stage
         logic [RW-1:0]   p_rem;
         logic [RB-1:0]   p_root;
         logic [2*RB-1:0] p_rad;
         logic [SW-1:0]   p_side;
         logic            p_valid;
         logic [RW-1:0]   cur;
         logic [RW:0]     trial;
         logic            ge;
         logic [RW-1:0]   rem_in;
         logic [RB-1:0]   root_in;

         if (k == 0) begin : g_first
            assign p_rem   = '0;
            assign p_root  = '0;
            assign p_rad   = radicand;
            assign p_side  = in_side;
            assign p_valid = in_valid;
         end else begin : g_next
            assign p_rem   = rem_ff[k-1];
            assign p_root  = root_ff[k-1];
            assign p_rad   = rad_ff[k-1];
            assign p_side  = side_ff[k-1];
            assign p_valid = valid_ff[k-1];
         end

         always_comb begin
            cur     = {p_rem[RW-3:0], p_rad[2*RB-1 -: 2]};
            trial   = {1'b0, cur} - {2'b00, p_root, 2'b01};
            ge      = ~trial[RW];
            rem_in  = ge ? trial[RW-1:0] : cur;
            root_in = {p_root[RB-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en) begin
               valid_ff[k] <= p_valid;
            end
            if (en) begin
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
               rad_ff[k]  <= {p_rad[2*RB-3:0], 2'b00};
               side_ff[k] <= p_side;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[RB-1];
   assign root      = root_ff[RB-1];
   assign out_side  = side_ff[RB-1];

endmodule

### rtl/mhws_div.sv
// pipelined restoring divider, one quotient bit per stage
// the upper part of the dividend must be below the divisor
module mhws_div #(
   parameter int VW = 26,
   parameter int QB = 24,
   parameter int SW = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [VW+QB-1:0] dividend,
   input  logic [VW-1:0]    divisor,
   input  logic [SW-1:0]    in_side,
   output logic             out_valid,
   output logic [QB-1:0]    quotient,
   output logic [SW-1:0]    out_side
);

   logic [VW:0]   rem_ff  [QB];
   logic [QB-1:0] lo_ff   [QB];
   logic [QB-1:0] q_ff    [QB];
   logic [VW-1:0] dvs_ff  [QB];
   logic [SW-1:0] side_ff [QB];
   logic [QB-1:0] valid_ff;

   genvar k;
   generate
      for (k = 0; k < QB; k++) begin : g_stage
         logic [VW:0]   p_rem;
         logic [QB-1:0] p_lo;
         logic [QB-1:0] p_q;
         logic [VW-1:0] p_dvs;
         logic [SW-1:0] p_side;
         logic          p_valid;
         logic [VW:0]   cur;
         logic [VW+1:0] trial;
         logic          ge;

         if (k == 0) begin : g_first
            assign p_rem   = {1'b0, dividend[VW+QB-1 -: VW]};
            assign p_lo    = dividend[QB-1:0];
            assign p_q     = '0;
            assign p_dvs   = divisor;
            assign p_side  = in_side;
            assign p_valid = in_valid;
         end else begin : g_next
            assign p_rem   = rem_ff[k-1];
            assign p_lo    = lo_ff[k-1];
            assign p_q     = q_ff[k-1];
            assign p_dvs   = dvs_ff[k-1];
            assign p_side  = side_ff[k-1];
            assign p_valid = valid_ff[k-1];
         end

         always_comb begin
            cur   = {p_rem[VW-1:0], p_lo[QB-1]};
            trial = {1'b0, cur} - {2'b00, p_dvs};
            ge    = ~trial[VW+1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en) begin
               valid_ff[k] <= p_valid;
            end
            if (en) begin
               rem_ff[k]  <= ge ? trial[VW:0] : cur;
               lo_ff[k]   <= {p_lo[QB-2:0], 1'b0};
               q_ff[k]    <= {p_q[QB-2:0], ge};
               dvs_ff[k]  <= p_dvs;
               side_ff[k] <= p_side;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[QB-1];
   assign quotient  = q_ff[QB-1];
   assign out_side  = side_ff[QB-1];

endmodule

### rtl/mecanum_heading_to_wheel_speeds_top.sv
// channel   | ports                                              | role
// ----------+----------------------------------------------------+-------------------------
// request   | req_valid/req_ready, speed, spin, offset x/y       | one drive command
// response  | rsp_valid/rsp_ready, four wheel speeds, saturated  | wheel targets per command
// csr       | csr_write_enable, csr_write_data                   | spin mixing gain, Q0.16
//
// one transaction enters per cycle while no response is stalled; registers in order: stage 1,
// stage 2, the bit-per-stage root and divider pipelines, the wheel sums, the output
// the whole pipeline advances together; it holds only while a response is offered and not taken
// reset (synchronous) clears all valid bits and loads the default gain
module mecanum_heading_to_wheel_speeds_top #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_linear_speed,
   input  logic signed [8:0]     req_spin_speed,
   input  logic signed [COORD_BITS-1:0] req_offset_x,
   input  logic signed [COORD_BITS-1:0] req_offset_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [9:0]     rsp_left_front_speed,
   output logic signed [9:0]     rsp_right_front_speed,
   output logic signed [9:0]     rsp_left_rear_speed,
   output logic signed [9:0]     rsp_right_rear_speed,
   output logic                  rsp_saturated,
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data
);

   localparam int N     = COORD_BITS;
   localparam int F     = FRAC_BITS;
   localparam int SPW   = mhws_pkg::SPEED_BITS;
   localparam int PRODW = SPW + N;               // speed times offset magnitude
   localparam int RB    = N + F;                 // root width
   localparam int QB    = SPW + F;               // quotient width
   localparam int STW   = mhws_pkg::SPIN_BITS + F; // spin term width
   localparam int SUMW  = QB + 3;                // wheel sum width
   localparam int SSW   = 2 * PRODW + 3 + STW;   // root stage sidecar
   localparam int XSW   = 2 + STW;               // x divider sidecar
   localparam int WB    = mhws_pkg::WHEEL_BITS;

   // global advance: whole pipe moves unless a response is stuck
   logic rsp_valid_ff;
   logic en;
   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;

   // gain register
   logic [15:0] gain_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= mhws_pkg::GAIN_RESET;
      end else if (csr_write_enable) begin
         gain_ff <= csr_write_data;
      end
   end

   // gain moved from Q0.16 to QF
   logic [F+15:0] gain_wide;
   logic [F-1:0]  gain_q;
   assign gain_wide = {gain_ff, {F{1'b0}}};
   assign gain_q    = gain_wide[F+15:16];

   // stage 1: magnitudes, y of sixty folded to zero, spin term
   logic                 y_is_sixty;
   logic signed [N-1:0]  y_fix;
   logic [N-1:0]         magx_in, magy_in;
   logic signed [STW:0]  st_prod;

   always_comb begin
      y_is_sixty = ({{(32-N){req_offset_y[N-1]}}, req_offset_y} == 32'(mhws_pkg::Y_AS_ZERO));
      y_fix      = y_is_sixty ? '0 : req_offset_y;
      magx_in    = req_offset_x[N-1] ? N'(-req_offset_x) : req_offset_x;
      magy_in    = y_fix[N-1] ? N'(-y_fix) : y_fix;
      st_prod    = req_spin_speed * $signed({1'b0, gain_q});
   end

   logic             v1_ff;
   logic [SPW-1:0]   speed1_ff;
   logic [N-1:0]     magx1_ff, magy1_ff;
   logic             sx1_ff, sy1_ff, zero1_ff;
   logic [STW-1:0]   st1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
      if (en) begin
         speed1_ff <= req_linear_speed;
         magx1_ff  <= magx_in;
         magy1_ff  <= magy_in;
         sx1_ff    <= req_offset_x[N-1];
         sy1_ff    <= y_fix[N-1];
         zero1_ff  <= (magx_in == '0) && (magy_in == '0);
         st1_ff    <= st_prod[STW-1:0];
      end
   end

   // stage 2: squares and speed products
   logic             v2_ff;
   logic [2*N-1:0]   sqx2_ff, sqy2_ff;
   logic [PRODW-1:0] px2_ff, py2_ff;
   logic             sx2_ff, sy2_ff, zero2_ff;
   logic [STW-1:0]   st2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         sqx2_ff  <= magx1_ff * magx1_ff;
         sqy2_ff  <= magy1_ff * magy1_ff;
         px2_ff   <= speed1_ff * magx1_ff;
         py2_ff   <= speed1_ff * magy1_ff;
         sx2_ff   <= sx1_ff;
         sy2_ff   <= sy1_ff;
         zero2_ff <= zero1_ff;
         st2_ff   <= st1_ff;
      end
   end

   // vector length in QF
   logic [2*N-1:0]  sq2;
   logic            sqrt_valid;
   logic [RB-1:0]   len;
   logic [SSW-1:0]  sqrt_side;
   assign sq2 = sqx2_ff + sqy2_ff;

   mhws_sqrt #(.RB(RB), .SW(SSW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .radicand  ({sq2, {(2*F){1'b0}}}),
      .in_side   ({px2_ff, py2_ff, sx2_ff, sy2_ff, zero2_ff, st2_ff}),
      .out_valid (sqrt_valid),
      .root      (len),
      .out_side  (sqrt_side)
   );

   logic [PRODW-1:0] px3, py3;
   logic             sx3, sy3, zero3;
   logic [STW-1:0]   st3;
   assign {px3, py3, sx3, sy3, zero3, st3} = sqrt_side;

   // vx and vy magnitudes
   logic            dx_valid, dy_valid;
   logic [QB-1:0]   qx, qy;
   logic [XSW-1:0]  dx_side;
   logic            dy_side;

   mhws_div #(.VW(RB), .QB(QB), .SW(XSW)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqrt_valid),
      .dividend  ({px3, {(2*F){1'b0}}}),
      .divisor   (len),
      .in_side   ({sx3, zero3, st3}),
      .out_valid (dx_valid),
      .quotient  (qx),
      .out_side  (dx_side)
   );

   mhws_div #(.VW(RB), .QB(QB), .SW(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqrt_valid),
      .dividend  ({py3, {(2*F){1'b0}}}),
      .divisor   (len),
      .in_side   (sy3),
      .out_valid (dy_valid),
      .quotient  (qy),
      .out_side  (dy_side)
   );

   logic            sx4, zero4;
   logic [STW-1:0]  st4;
   assign {sx4, zero4, st4} = dx_side;

   // wheel sums in QF; zero offset means spin only, otherwise translation only
   logic [SUMW-1:0] vx, vy, spn;
   logic [SUMW-1:0] sum_in [4];

   always_comb begin
      vx = SUMW'({1'b0, qx});
      vy = SUMW'({1'b0, qy});
      if (sx4) vx = -vx;
      if (dy_side) vy = -vy;
      spn = {{(SUMW-STW){st4[STW-1]}}, st4};
      if (zero4) begin
         vx = '0;
         vy = '0;
      end else begin
         spn = '0;
      end
      sum_in[0] =  vx + vy - spn;
      sum_in[1] = -vx + vy + spn;
      sum_in[2] = -vx + vy - spn;
      sum_in[3] =  vx + vy + spn;
   end

   logic            v5_ff;
   logic [SUMW-1:0] sum_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= dx_valid & dy_valid;
      end
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            sum_ff[i] <= sum_in[i];
         end
      end
   end

   // cut toward zero, then clamp to the wheel range
   logic [WB-1:0]     wheel_in [4];
   logic [3:0]        clip;
   logic [SUMW-1:0]   abs_s;
   logic [SUMW-F-1:0] whole;
   logic [WB-1:0]     lim;

   always_comb begin
      abs_s = '0;
      whole = '0;
      lim   = '0;
      for (int i = 0; i < 4; i++) begin
         abs_s   = sum_ff[i][SUMW-1] ? -sum_ff[i] : sum_ff[i];
         whole   = abs_s[SUMW-1:F];
         clip[i] = whole > (SUMW-F)'(mhws_pkg::WHEEL_LIMIT);
         lim     = clip[i] ? WB'(mhws_pkg::WHEEL_LIMIT) : whole[WB-1:0];
         wheel_in[i] = sum_ff[i][SUMW-1] ? -lim : lim;
      end
   end

   logic [WB-1:0]  lf_ff, rf_ff, lr_ff, rr_ff;
   logic           sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v5_ff;
      end
      if (en) begin
         lf_ff  <= wheel_in[0];
         rf_ff  <= wheel_in[1];
         lr_ff  <= wheel_in[2];
         rr_ff  <= wheel_in[3];
         sat_ff <= |clip;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_left_front_speed  = lf_ff;
   assign rsp_right_front_speed = rf_ff;
   assign rsp_left_rear_speed   = lr_ff;
   assign rsp_right_rear_speed  = rr_ff;
   assign rsp_saturated         = sat_ff;

endmodule

### rtl/mhws_checker.sv
module mhws_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [9:0] rsp_left_front_speed,
   input logic [9:0] rsp_right_front_speed,
   input logic [9:0] rsp_left_rear_speed,
   input logic [9:0] rsp_right_rear_speed
);

   logic [19:0] rsp_rear_pair;
   assign rsp_rear_pair = {rsp_left_rear_speed, rsp_right_rear_speed};

   // a stalled response stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // left front and both rear speeds steady under stall
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_left_front_speed) && $stable(rsp_rear_pair))
      else $error("response payload changed while stalled");

   // request side opens exactly when the response slot can move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response slot");

   // clamp never yields the most negative code
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_front_speed != 10'h200 && rsp_right_front_speed != 10'h200
                    && rsp_left_rear_speed != 10'h200 && rsp_right_rear_speed != 10'h200)
      else $error("wheel speed outside clamp range");

   // nothing offered right after reset
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind mecanum_heading_to_wheel_speeds_top mhws_checker u_mhws_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_left_front_speed  (rsp_left_front_speed),
   .rsp_right_front_speed (rsp_right_front_speed),
   .rsp_left_rear_speed   (rsp_left_rear_speed),
   .rsp_right_rear_speed  (rsp_right_rear_speed)
);
